@@ rtl/ra_pkg.sv @@
// ----------------------------------------------------------------------------
// ra_pkg: shared types and constants of the rank assignment block
// Holds the command passed from the front end to the ranking back end.
// ----------------------------------------------------------------------------
package ra_pkg;

    localparam int VALUE_W   = 32;
    localparam int RANK_W    = 7;
    localparam int CMD_DEPTH = 4;
    localparam int GROUP_W   = 8;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      store;
        logic                      last;
        logic                      ovf;
    } cmd_t;

endpackage

@@ rtl/ra_front.sv @@
// ----------------------------------------------------------------------------
// ra_front: request intake and classification
// Decides whether each value is stored or dropped and tracks the drop flag.
// ----------------------------------------------------------------------------
module ra_front import ra_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      last_item,
    output logic                      cmd_push,
    output cmd_t                      cmd,
    input  logic                      cmd_full
);

    localparam int FILL_W = $clog2(MAX_ITEMS + 1);

    logic [FILL_W-1:0] count_reg;
    logic [FILL_W-1:0] count_next;
    logic              dropped_reg;
    logic              dropped_next;
    logic              accept;
    logic              store;

    assign full      = cmd_full;
    assign accept    = push && !cmd_full;
    assign store     = count_reg < FILL_W'(MAX_ITEMS);
    assign cmd_push  = accept;
    assign cmd.value = value;
    assign cmd.store = store;
    assign cmd.last  = last_item;
    assign cmd.ovf   = dropped_reg | !store;

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (accept)
        begin
            if (last_item)
            begin
                count_next   = '0;
                dropped_next = 1'b0;
            end
            else if (store)
            begin
                count_next = count_reg + FILL_W'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

@@ rtl/ra_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// ra_cmd_fifo: command queue between front end and back end
// A short first-in first-out buffer so that either side can stall alone.
// ----------------------------------------------------------------------------
module ra_cmd_fifo import ra_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             fifo_q [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] level_reg;
    logic [CNT_W-1:0] level_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = level_reg == CNT_W'(CMD_DEPTH);
    assign empty   = level_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = fifo_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            level_next = level_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            level_next = level_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            fifo_q[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

@@ rtl/ra_back.sv @@
// ----------------------------------------------------------------------------
// ra_back: ranking cells and result emission
// Each cell keeps a value and the count of stored values below it; counts
// are updated by parallel compares and shifted out as ranks after the end.
// ----------------------------------------------------------------------------
module ra_back import ra_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  cmd_t              cmd_head,
    output logic              cmd_pop,
    output logic              empty,
    input  logic              pop,
    output logic [RANK_W-1:0] rank,
    output logic              overflowed,
    output logic              last_rank
);

    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int FILL_W = $clog2(MAX_ITEMS + 1);
    localparam int CNT_W  = IDX_W;
    localparam int NGRP   = (MAX_ITEMS + GROUP_W - 1) / GROUP_W;
    localparam int PAD_W  = NGRP * GROUP_W;
    localparam int PART_W = $clog2(GROUP_W + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_WRITE,
        S_EMIT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              last_reg;
    logic              last_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;
    logic              out_ovf_reg;
    logic              out_ovf_next;
    logic              last_rank_reg;
    logic              last_rank_next;

    logic signed [VALUE_W-1:0] cell_value_reg [MAX_ITEMS];
    logic [CNT_W-1:0]          cell_cnt_reg   [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]      lt_reg;
    logic [MAX_ITEMS-1:0]      lt_next;
    logic [MAX_ITEMS-1:0]      gt_reg;
    logic [MAX_ITEMS-1:0]      gt_next;
    logic [PART_W-1:0]         part_reg  [NGRP];
    logic [PART_W-1:0]         part_next [NGRP];
    logic [PAD_W-1:0]          lt_pad;
    logic [CNT_W-1:0]          total;
    logic                      load_ok;
    logic                      take_store;
    logic                      emit_now;

    assign empty      = !out_valid_reg;
    assign rank       = rank_reg;
    assign overflowed = out_ovf_reg;
    assign last_rank  = last_rank_reg;
    assign load_ok    = !out_valid_reg || pop;
    assign cmd_pop    = (state_reg == S_IDLE) && !cmd_empty;
    assign take_store = cmd_pop && cmd_head.store;
    assign emit_now   = (state_reg == S_EMIT) && load_ok;
    assign lt_pad     = PAD_W'(lt_reg);

    // Each valid cell compares its value against the incoming one.
    always_comb
    begin
        for (int k = 0; k < MAX_ITEMS; k++)
        begin
            lt_next[k] = (FILL_W'(k) < fill_reg) && (cell_value_reg[k] < cmd_head.value);
            gt_next[k] = (FILL_W'(k) < fill_reg) && (cmd_head.value < cell_value_reg[k]);
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            part_next[g] = '0;
            for (int b = 0; b < GROUP_W; b++)
            begin
                part_next[g] = part_next[g] + PART_W'(lt_pad[g * GROUP_W + b]);
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            total = total + CNT_W'(part_reg[g]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !pop;
        rank_next      = rank_reg;
        out_ovf_next   = out_ovf_reg;
        last_rank_next = last_rank_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    ovf_next  = cmd_head.ovf;
                    last_next = cmd_head.last;
                    if (cmd_head.store)
                    begin
                        state_next = S_SUM;
                    end
                    else if (cmd_head.last)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_SUM:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                fill_next  = fill_reg + FILL_W'(1);
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    rank_next      = RANK_W'(cell_cnt_reg[0]) + RANK_W'(1);
                    out_ovf_next   = ovf_reg;
                    last_rank_next = fill_reg == FILL_W'(1);
                    fill_next      = fill_reg - FILL_W'(1);
                    if (fill_reg == FILL_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take_store)
        begin
            cell_value_reg[fill_reg[IDX_W-1:0]] <= cmd_head.value;
            lt_reg                              <= lt_next;
            gt_reg                              <= gt_next;
        end
        if (state_reg == S_SUM)
        begin
            for (int k = 0; k < MAX_ITEMS; k++)
            begin
                if (gt_reg[k])
                begin
                    cell_cnt_reg[k] <= cell_cnt_reg[k] + CNT_W'(1);
                end
            end
            for (int g = 0; g < NGRP; g++)
            begin
                part_reg[g] <= part_next[g];
            end
        end
        if (state_reg == S_WRITE)
        begin
            cell_cnt_reg[fill_reg[IDX_W-1:0]] <= total;
        end
        if (emit_now)
        begin
            for (int k = 0; k < MAX_ITEMS - 1; k++)
            begin
                cell_cnt_reg[k] <= cell_cnt_reg[k + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rank_reg      <= '0;
            out_ovf_reg   <= 1'b0;
            last_rank_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            rank_reg      <= rank_next;
            out_ovf_reg   <= out_ovf_next;
            last_rank_reg <= last_rank_next;
        end
    end

endmodule

@@ rtl/rank_assign.sv @@
// ----------------------------------------------------------------------------
// rank_assign: rank transform of a value sequence
// Input requests carry a signed value and an end flag; write with push while
// full is low. Results come out with empty low and are taken with pop.
// Each stored value gets one result, in arrival order, whose rank is one plus
// the number of stored values strictly smaller, so equal values share a rank.
// Values past MAX_ITEMS are dropped and overflowed is set on every result of
// that sequence; last_rank marks the result of the final stored value.
// A stored value passes through the ranking cells in steps: parallel compare,
// count update with partial sums, and the final sum written into its cell.
// After the last request, results come out one per cycle while pop is held.
// A four-entry command queue lets requests arrive while the cells are busy.
// When pop stays low the output register holds its result and the cells
// wait; the queue then fills and full rises.
// Reset clears the queue, the fill counts and the output register; the cell values and counts are not reset.
// ----------------------------------------------------------------------------
module rank_assign import ra_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      last_item,
    output logic                      empty,
    input  logic                      pop,
    output logic [RANK_W-1:0]         rank,
    output logic                      overflowed,
    output logic                      last_rank
);

    cmd_t cmd_wr;
    cmd_t cmd_head;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;

    ra_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .last_item (last_item),
        .cmd_push  (cmd_push),
        .cmd       (cmd_wr),
        .cmd_full  (cmd_full)
    );

    ra_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wr),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .empty   (cmd_empty)
    );

    ra_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd_head   (cmd_head),
        .cmd_pop    (cmd_pop),
        .empty      (empty),
        .pop        (pop),
        .rank       (rank),
        .overflowed (overflowed),
        .last_rank  (last_rank)
    );

endmodule
